FILE: src/ghalloc_pkg.sv
// Shared types and codes for the generational handle allocator.
// Holds the operation and status encodings; no dependencies.
package ghalloc_pkg;

    typedef enum logic [1:0] {
        OP_ALLOC     = 2'd0,
        OP_RELEASE   = 2'd1,
        OP_LOOKUP    = 2'd2,
        OP_GEN_QUERY = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_FULL        = 2'd1,
        ST_BAD_RELEASE = 2'd2,
        ST_BAD_HANDLE  = 2'd3
    } t_status;

    localparam int unsigned IDX_PORT_W = 16;
    localparam int unsigned GEN_PORT_W = 32;
    localparam int unsigned REF_W      = 32;

endpackage

FILE: src/ghalloc_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Stand-alone; used for the slot table and the free stack.
module ghalloc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/generational_handle_allocator_top.sv
// Top level of the generational handle allocator.
// Depends on ghalloc_pkg and two instances of ghalloc_ram.

// The block keeps a table of slots, each holding an object reference, a
// generation counter and a live flag, in one synchronous RAM, and a LIFO of
// freed slot indexes in a second RAM. Allocate takes the most recently freed
// slot, or else the next never-used one, and hands out (index, generation).
// Release clears the slot, bumps its generation and pushes the index. Lookup
// checks a handle against the slot's current generation; a generation query
// reads it. Every item produces exactly one result item. An item reads the
// slot entry, then updates it and registers the result. An allocate that
// reuses a freed slot first reads the free stack, because that read must
// finish before the slot entry can be addressed. Only one item is in
// flight, so a write always completes before the next read of the same
// entry. Results wait in an output register, and the next item is
// accepted while a result is still stalled there; that item then holds in
// its update step until the register empties. Nothing needs clearing after
// reset: a slot is only read once the fill count shows it was opened, and
// opening writes the whole entry, so the block is ready right out of reset.
module generational_handle_allocator_top
    import ghalloc_pkg::*;
#(
    parameter int unsigned SLOT_COUNT = 1024,
    parameter int unsigned GEN_WIDTH  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Request channel.
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_operation,
    input  logic [IDX_PORT_W-1:0] i_slot_index,
    input  logic [GEN_PORT_W-1:0] i_handle_generation,
    input  logic [REF_W-1:0]      i_object_ref,
    // Result channel.
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [1:0]            o_status,
    output logic [IDX_PORT_W-1:0] o_result_index,
    output logic [GEN_PORT_W-1:0] o_result_generation,
    output logic [REF_W-1:0]      o_result_ref,
    output logic                  o_handle_valid
);

    localparam int unsigned IDX_W  = $clog2(SLOT_COUNT);
    localparam int unsigned CNT_W  = $clog2(SLOT_COUNT + 1);
    // Width at which generations and handle generations are compared.
    localparam int unsigned CMP_W  = (GEN_WIDTH > GEN_PORT_W) ? GEN_WIDTH : GEN_PORT_W;
    // Slot entry layout: {live, generation, reference}.
    localparam int unsigned SLOT_W = 1 + GEN_WIDTH + REF_W;
    // Range checks compare the 16-bit index against the fill count.
    localparam int unsigned RNG_W  = IDX_PORT_W + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_EXEC
    } t_state;

    t_state                r_state, n_state;
    t_op                   r_op, n_op;
    logic [IDX_PORT_W-1:0] r_idx, n_idx;
    logic [GEN_PORT_W-1:0] r_hgen, n_hgen;
    logic [REF_W-1:0]      r_oref, n_oref;
    logic [IDX_W-1:0]      r_slot, n_slot;
    logic                  r_fresh, n_fresh;
    logic                  r_full, n_full;
    logic                  r_in_range, n_in_range;
    logic [CNT_W-1:0]      r_free_count, n_free_count;
    logic [CNT_W-1:0]      r_used, n_used;

    logic                  r_out_valid, n_out_valid;
    t_status               r_status, n_status;
    logic [IDX_PORT_W-1:0] r_res_idx, n_res_idx;
    logic [GEN_PORT_W-1:0] r_res_gen, n_res_gen;
    logic [REF_W-1:0]      r_res_ref, n_res_ref;
    logic                  r_res_valid, n_res_valid;

    // Memory ports.
    logic                  slot_wr_en, slot_rd_en;
    logic [IDX_W-1:0]      slot_wr_addr, slot_rd_addr;
    logic [SLOT_W-1:0]     slot_wr_data, slot_rd_data;
    logic                  stk_wr_en, stk_rd_en;
    logic [IDX_W-1:0]      stk_wr_addr, stk_rd_addr;
    logic [IDX_W-1:0]      stk_rd_data;

    logic                  accept;
    logic                  exec_fire;
    logic                  in_range_now;
    logic [CNT_W-1:0]      free_dec;
    logic                  rd_live;
    logic [GEN_WIDTH-1:0]  rd_gen;
    logic [REF_W-1:0]      rd_ref;
    logic [GEN_WIDTH-1:0]  base_gen;
    logic [GEN_WIDTH-1:0]  next_gen;
    logic [GEN_WIDTH-1:0]  cur_gen;
    logic [CMP_W-1:0]      next_gen_x;
    logic [CMP_W-1:0]      cur_gen_x;
    logic [CMP_W-1:0]      hgen_x;
    logic                  lookup_ok;

    assign accept       = i_valid && (r_state == S_IDLE);
    assign exec_fire    = (r_state == S_EXEC) && (!r_out_valid || !i_stall);
    assign in_range_now = {1'b0, i_slot_index} < RNG_W'(r_used);
    assign free_dec     = r_free_count - 1'b1;

    assign {rd_live, rd_gen, rd_ref} = slot_rd_data;

    // A freshly opened slot starts from generation zero; its entry is unread.
    assign base_gen   = r_fresh ? '0 : rd_gen;
    assign next_gen   = base_gen + 1'b1;
    assign cur_gen    = r_in_range ? rd_gen : '0;
    assign next_gen_x = CMP_W'(next_gen);
    assign cur_gen_x  = CMP_W'(cur_gen);
    assign hgen_x     = CMP_W'(r_hgen);
    assign lookup_ok  = (cur_gen_x != '0) && (hgen_x != '0) && (cur_gen_x == hgen_x);

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_idx        = r_idx;
        n_hgen       = r_hgen;
        n_oref       = r_oref;
        n_slot       = r_slot;
        n_fresh      = r_fresh;
        n_full       = r_full;
        n_in_range   = r_in_range;
        n_free_count = r_free_count;
        n_used       = r_used;
        n_out_valid  = r_out_valid;
        n_status     = r_status;
        n_res_idx    = r_res_idx;
        n_res_gen    = r_res_gen;
        n_res_ref    = r_res_ref;
        n_res_valid  = r_res_valid;

        slot_wr_en   = 1'b0;
        slot_wr_addr = r_slot;
        slot_wr_data = '0;
        slot_rd_en   = 1'b0;
        slot_rd_addr = i_slot_index[IDX_W-1:0];
        stk_wr_en    = 1'b0;
        stk_wr_addr  = r_free_count[IDX_W-1:0];
        stk_rd_en    = 1'b0;
        stk_rd_addr  = free_dec[IDX_W-1:0];

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op       = t_op'(i_operation);
                    n_idx      = i_slot_index;
                    n_hgen     = i_handle_generation;
                    n_oref     = i_object_ref;
                    n_slot     = i_slot_index[IDX_W-1:0];
                    n_fresh    = 1'b0;
                    n_full     = 1'b0;
                    n_in_range = in_range_now;
                    n_state    = S_EXEC;
                    if (t_op'(i_operation) == OP_ALLOC) begin
                        if (r_free_count != '0) begin
                            // Pop the most recently freed index.
                            stk_rd_en    = 1'b1;
                            n_free_count = free_dec;
                            n_state      = S_POP;
                        end else if (r_used != CNT_W'(SLOT_COUNT)) begin
                            n_slot  = r_used[IDX_W-1:0];
                            n_fresh = 1'b1;
                            n_used  = r_used + 1'b1;
                        end else begin
                            n_full = 1'b1;
                        end
                    end else begin
                        slot_rd_en = in_range_now;
                    end
                end
            end
            S_POP: begin
                n_slot       = stk_rd_data;
                slot_rd_addr = stk_rd_data;
                slot_rd_en   = 1'b1;
                n_state      = S_EXEC;
            end
            S_EXEC: begin
                if (exec_fire) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_res_idx   = r_idx;
                    n_res_gen   = cur_gen_x[GEN_PORT_W-1:0];
                    n_res_ref   = '0;
                    n_res_valid = 1'b0;
                    unique case (r_op)
                        OP_ALLOC: begin
                            if (r_full) begin
                                n_status  = ST_FULL;
                                n_res_idx = '0;
                                n_res_gen = '0;
                            end else begin
                                slot_wr_en   = 1'b1;
                                slot_wr_data = {1'b1, next_gen, r_oref};
                                n_res_idx    = IDX_PORT_W'(r_slot);
                                n_res_gen    = next_gen_x[GEN_PORT_W-1:0];
                            end
                        end
                        OP_RELEASE: begin
                            if (!r_in_range || !rd_live) begin
                                n_status = ST_BAD_RELEASE;
                            end else begin
                                slot_wr_en   = 1'b1;
                                slot_wr_data = {1'b0, next_gen, {REF_W{1'b0}}};
                                stk_wr_en    = 1'b1;
                                n_free_count = r_free_count + 1'b1;
                                n_res_gen    = next_gen_x[GEN_PORT_W-1:0];
                            end
                        end
                        OP_LOOKUP: begin
                            if (lookup_ok) begin
                                n_res_ref   = rd_ref;
                                n_res_valid = 1'b1;
                            end else begin
                                n_status = ST_BAD_HANDLE;
                            end
                        end
                        OP_GEN_QUERY: begin
                            n_status = ST_OK;
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_free_count <= '0;
            r_used       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_free_count <= n_free_count;
            r_used       <= n_used;
            r_out_valid  <= n_out_valid;
        end
        r_op        <= n_op;
        r_idx       <= n_idx;
        r_hgen      <= n_hgen;
        r_oref      <= n_oref;
        r_slot      <= n_slot;
        r_fresh     <= n_fresh;
        r_full      <= n_full;
        r_in_range  <= n_in_range;
        r_status    <= n_status;
        r_res_idx   <= n_res_idx;
        r_res_gen   <= n_res_gen;
        r_res_ref   <= n_res_ref;
        r_res_valid <= n_res_valid;
    end

    ghalloc_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (slot_wr_en),
        .i_wr_addr (slot_wr_addr),
        .i_wr_data (slot_wr_data),
        .i_rd_en   (slot_rd_en),
        .i_rd_addr (slot_rd_addr),
        .o_rd_data (slot_rd_data)
    );

    ghalloc_ram #(
        .WIDTH (IDX_W),
        .DEPTH (SLOT_COUNT)
    ) u_free_stack (
        .i_clk     (i_clk),
        .i_wr_en   (stk_wr_en),
        .i_wr_addr (stk_wr_addr),
        .i_wr_data (r_slot),
        .i_rd_en   (stk_rd_en),
        .i_rd_addr (stk_rd_addr),
        .o_rd_data (stk_rd_data)
    );

    assign o_stall             = (r_state != S_IDLE);
    assign o_valid             = r_out_valid;
    assign o_status            = r_status;
    assign o_result_index      = r_res_idx;
    assign o_result_generation = r_res_gen;
    assign o_result_ref        = r_res_ref;
    assign o_handle_valid      = r_res_valid;

endmodule
